>>> src/slps_pkg.sv
package slps_pkg;

   // pattern codes as seen on the result
   localparam logic [1:0] PAT_IDLE  = 2'd0;
   localparam logic [1:0] PAT_FAULT = 2'd1;
   localparam logic [1:0] PAT_BOOST = 2'd2;
   localparam logic [1:0] PAT_PULSE = 2'd3;

   localparam logic [7:0]  FULL_LEVEL      = 8'd255;
   localparam logic [7:0]  ORANGE_GREEN    = 8'd165;
   localparam logic [7:0]  DIM_LEVEL       = 8'd50;
   localparam logic [4:0]  FIXED_LEN       = 5'd10;
   localparam logic [4:0]  BLINK_HALF      = 5'd5;
   localparam logic [15:0] MAX_POWER_RESET = 16'd1000;

   // serial divider: quotient always fits 8 bits for every use here
   localparam int DIV_NUM_W = 24;
   localparam int DIV_DEN_W = 16;
   localparam int DIV_Q_W   = 8;
   localparam int DIV_CNT_W = 4;

   typedef struct packed {
      logic                fault_active;
      logic [31:0]         boost_end_sec;
      logic [31:0]         now_sec;
      logic signed [15:0]  equipment_power_w;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [1:0] pattern;
   } rsp_type;

endpackage

>>> src/status_led_pattern_sequencer.sv
// Channel   Direction  Ports                          Carries
// request   in         req_valid/req_stall/req_data   one 100 ms status tick
// response  out        rsp_valid/rsp_stall/rsp_data   RGB level and pattern code
// csr       in         csr_wr_en/csr_wr_data          max_power_w, write only
//
// One request at a time. From accept, a fixed pattern steps through choose,
// colour and output; a pulse tick also runs serial divisions for red and green,
// plus one for its base level when it picks the pulse at the pattern start; the
// machine is back in idle as the response is presented. Each division has 8 steps.
// A finished response sits in the output register; the next request is taken
// meanwhile, and a response stall only holds the machine once the next one is
// ready. Reset is synchronous: first tick afterwards chooses a pattern.
module status_led_pattern_sequencer
   import slps_pkg::*;
#(
   parameter int PULSE_STEPS = 10
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   // pulse runs 2*PULSE_STEPS ticks; 6 bits so a 32-tick length compares cleanly
   localparam logic [5:0]  PULSE_LEN  = 6'(2 * PULSE_STEPS);
   localparam logic [5:0]  PULSE_HALF = 6'(PULSE_STEPS);
   localparam logic [15:0] STEPS_DEN  = 16'(PULSE_STEPS);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_CHOOSE = 7'b0000010,
      S_BASE   = 7'b0000100,
      S_COLOUR = 7'b0001000,
      S_RED    = 7'b0010000,
      S_GREEN  = 7'b0100000,
      S_OUT    = 7'b1000000
   } state_type;

   state_type   state_ff, state_in;
   req_type     req_ff, req_in;
   rsp_type     colour_ff, colour_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] max_power_ff, max_power_in;
   logic [1:0]  active_pattern_ff, active_pattern_in;
   logic [4:0]  step_count_ff, step_count_in;
   logic [7:0]  base_level_ff, base_level_in;

   // divider hookup
   logic                 div_start;
   logic [DIV_NUM_W-1:0] div_dividend;
   logic [DIV_DEN_W-1:0] div_divisor;
   logic                 div_done;
   logic [DIV_Q_W-1:0]   div_quot;

   // pattern choice terms
   logic [31:0] boost_diff;
   logic        boost_on;
   logic [15:0] full_scale;
   logic [15:0] power_sat;
   logic [15:0] headroom;
   logic [1:0]  pattern_sel;

   // pulse terms
   logic [5:0]  step_wide;
   logic [4:0]  pulse_k;
   logic [12:0] base_k;
   logic [12:0] ramp_k;
   logic        out_load;

   slps_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      // boost live while the end is set and the wrapped end-minus-now is strictly positive
      boost_diff = req_ff.boost_end_sec - req_ff.now_sec;
      boost_on   = (req_ff.boost_end_sec != '0) && (boost_diff != '0) && !boost_diff[31];
      full_scale = (max_power_ff == '0) ? 16'd1 : max_power_ff;
      // only used when power is positive, so the raw bits are the magnitude
      power_sat  = (16'(req_ff.equipment_power_w) < full_scale) ?
                   16'(req_ff.equipment_power_w) : full_scale;
      headroom   = full_scale - power_sat;

      if (req_ff.fault_active) begin
         pattern_sel = PAT_FAULT;
      end else if (boost_on) begin
         pattern_sel = PAT_BOOST;
      end else if (req_ff.equipment_power_w[15] || (req_ff.equipment_power_w == '0)) begin
         pattern_sel = PAT_IDLE;
      end else begin
         pattern_sel = PAT_PULSE;
      end

      // intensity index: rises 1..N then falls back to 1
      step_wide = {1'b0, step_count_ff};
      if (step_wide < PULSE_HALF) begin
         pulse_k = 5'(step_wide + 6'd1);
      end else begin
         pulse_k = 5'(PULSE_LEN - step_wide);
      end
      base_k = {5'b0, base_level_ff} * {8'b0, pulse_k};
      ramp_k = {pulse_k, 8'h00} - {8'h00, pulse_k};
   end

   always_comb begin
      state_in          = state_ff;
      req_in            = req_ff;
      colour_in         = colour_ff;
      rsp_data_in       = rsp_data_ff;
      rsp_valid_in      = rsp_valid_ff;
      max_power_in      = max_power_ff;
      active_pattern_in = active_pattern_ff;
      step_count_in     = step_count_ff;
      base_level_in     = base_level_ff;
      div_start         = 1'b0;
      div_dividend      = '0;
      div_divisor       = '0;
      out_load          = 1'b0;

      if (csr_wr_en) begin
         max_power_in = csr_wr_data;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_CHOOSE;
            end
         end
         S_CHOOSE: begin
            state_in = S_COLOUR;
            if (step_count_ff == '0) begin
               active_pattern_in = pattern_sel;
               if (pattern_sel == PAT_PULSE) begin
                  // base = floor(255 * (m - p) / m)
                  div_start    = 1'b1;
                  div_dividend = {headroom, 8'h00} - {8'h00, headroom};
                  div_divisor  = full_scale;
                  state_in     = S_BASE;
               end
            end
         end
         S_BASE: begin
            if (div_done) begin
               base_level_in = div_quot;
               state_in      = S_COLOUR;
            end
         end
         S_COLOUR: begin
            colour_in = '0;
            if (active_pattern_ff == PAT_PULSE) begin
               div_start    = 1'b1;
               div_dividend = {11'b0, base_k};
               div_divisor  = STEPS_DEN;
               state_in     = S_RED;
            end else begin
               if (active_pattern_ff == PAT_FAULT) begin
                  colour_in.red = (step_count_ff < BLINK_HALF) ? FULL_LEVEL : 8'd0;
               end else if (active_pattern_ff == PAT_BOOST) begin
                  colour_in.red   = FULL_LEVEL;
                  colour_in.green = ORANGE_GREEN;
               end else begin
                  colour_in.red = DIM_LEVEL;
               end
               state_in = S_OUT;
            end
         end
         S_RED: begin
            if (div_done) begin
               colour_in.red  = div_quot;
               colour_in.blue = div_quot;
               div_start      = 1'b1;
               div_dividend   = {11'b0, ramp_k};
               div_divisor    = STEPS_DEN;
               state_in       = S_GREEN;
            end
         end
         S_GREEN: begin
            if (div_done) begin
               colour_in.green = div_quot;
               state_in        = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load            = 1'b1;
               rsp_data_in         = colour_ff;
               rsp_data_in.pattern = active_pattern_ff;
               rsp_valid_in        = 1'b1;
               // wrap to the boundary at the end of the pattern
               if (active_pattern_ff == PAT_PULSE) begin
                  step_count_in = (step_wide + 6'd1 >= PULSE_LEN) ? 5'd0 :
                                  5'(step_wide + 6'd1);
               end else begin
                  step_count_in = (step_count_ff + 5'd1 >= FIXED_LEN) ? 5'd0 :
                                  step_count_ff + 5'd1;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         rsp_valid_ff      <= 1'b0;
         max_power_ff      <= MAX_POWER_RESET;
         active_pattern_ff <= PAT_IDLE;
         step_count_ff     <= '0;
         base_level_ff     <= '0;
      end else begin
         state_ff          <= state_in;
         rsp_valid_ff      <= rsp_valid_in;
         max_power_ff      <= max_power_in;
         active_pattern_ff <= active_pattern_in;
         step_count_ff     <= step_count_in;
         base_level_ff     <= base_level_in;
      end
      req_ff      <= req_in;
      colour_ff   <= colour_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // fixed patterns never run past their length
   a_fixed_len: assert property (@(posedge clock) disable iff (reset)
      (active_pattern_ff != PAT_PULSE) |-> (step_count_ff < FIXED_LEN))
      else $error("step count past end of fixed pattern");

   // an accepted request always moves on to pattern choice
   a_accept_choose: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_CHOOSE))
      else $error("accepted request did not reach choose");

   // pulse green is at least floor(255/PULSE_STEPS), never dark
   a_pulse_green: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_OUT) && (active_pattern_ff == PAT_PULSE)) |-> (colour_ff.green != '0))
      else $error("pulse green level is zero");

   // a loaded response is presented on the next cycle
   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid)
      else $error("response lost after load");

endmodule

>>> src/slps_serial_div.sv
module slps_serial_div
   import slps_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] dividend,
   input  logic [DIV_DEN_W-1:0] divisor,
   output logic                 done,
   output logic [DIV_Q_W-1:0]   quotient
);

   // restoring division, one quotient bit per cycle, MSB first.
   // Caller guarantees dividend >> DIV_Q_W < divisor.
   logic [DIV_DEN_W:0]   rem_ff, rem_in;
   logic [DIV_Q_W-1:0]   low_ff, low_in;
   logic [DIV_Q_W-1:0]   quot_ff, quot_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   trial;
   logic                 fits;

   always_comb begin
      trial = {rem_ff[DIV_DEN_W-1:0], low_ff[DIV_Q_W-1]};
      fits  = (trial >= {1'b0, den_ff});
      rem_in  = rem_ff;
      low_in  = low_ff;
      quot_in = quot_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = {1'b0, dividend[DIV_NUM_W-1:DIV_Q_W]};
         low_in  = dividend[DIV_Q_W-1:0];
         den_in  = divisor;
         cnt_in  = DIV_CNT_W'(DIV_Q_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? (trial - {1'b0, den_ff}) : trial;
         low_in  = {low_ff[DIV_Q_W-2:0], 1'b0};
         quot_in = {quot_ff[DIV_Q_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
      den_ff  <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule
